/* rtl/core/bilw_pkg.sv */
// shared types, constants and opcode tables for the bytecode length walker
package bilw_pkg;

    // offset counter width; the counter wraps at this many bits
    localparam int unsigned OFFSET_BITS = 32;

    localparam int unsigned OPCODE_COUNT = 181;
    localparam int unsigned LEN_BITS     = 25;
    localparam int unsigned ACC_BITS     = 24;

    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // opcodes with a variable length rule
    localparam logic [7:0] OP_SCAN_HDR3      = 8'd37;
    localparam logic [7:0] OP_SCAN           = 8'd51;
    localparam logic [7:0] OP_FIELD16        = 8'd89;
    localparam logic [7:0] OP_FIELD8         = 8'd90;
    localparam logic [7:0] OP_FIELD16_HDR    = 8'd105;
    localparam logic [7:0] OP_FIELD8_HDR     = 8'd106;
    localparam logic [7:0] OP_SCAN_HDR4      = 8'd118;
    localparam logic [7:0] OP_HIDDEN_STR     = 8'd152;
    localparam logic [7:0] OP_FIELD24        = 8'd161;
    localparam logic [7:0] OP_FIELD24_HDR    = 8'd162;
    localparam logic [7:0] OP_THREAD_STATICS = 8'd179;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_OPCODE = 3'd1,
        ST_ZERO_SIZE  = 3'd2,
        ST_SHORT_LEN  = 3'd3,
        ST_TRUNCATED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LEN,
        KIND_SCAN
    } rule_kind_t;

    typedef struct packed {
        rule_kind_t kind;
        logic [2:0] hdr;   // header bytes, opcode included
        logic [1:0] fpos;  // first byte of the length field
        logic [1:0] fnum;  // bytes in the length field
        logic [2:0] add;   // added to the field
        logic       dbl;   // field doubled
    } var_rule_t;

    // one byte of the code stream held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] code_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [31:0]         start_offset;
        logic [LEN_BITS-1:0] instr_length;
        logic [7:0]          opcode_value;
        status_t             status;
    } result_t;

    // fixed instruction lengths; zero means variable length or invalid
    localparam logic [3:0] LEN_TAB [OPCODE_COUNT] = '{
        4'd1, 4'd1, 4'd1, 4'd3, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd3, 4'd2, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
        4'd2, 4'd1, 4'd9, 4'd1, 4'd1, 4'd2, 4'd3, 4'd4, 4'd2, 4'd3,
        4'd4, 4'd2, 4'd3, 4'd4, 4'd1, 4'd1, 4'd3, 4'd0, 4'd2, 4'd2,
        4'd2, 4'd3, 4'd2, 4'd1, 4'd2, 4'd2, 4'd1, 4'd1, 4'd3, 4'd1,
        4'd1, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd0,
        4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd4, 4'd1, 4'd1, 4'd1, 4'd3, 4'd2, 4'd3, 4'd3, 4'd3,
        4'd2, 4'd3, 4'd3, 4'd3, 4'd1, 4'd1, 4'd3, 4'd2, 4'd3, 4'd0,
        4'd0, 4'd3, 4'd2, 4'd3, 4'd3, 4'd2, 4'd3, 4'd5, 4'd3, 4'd3,
        4'd1, 4'd11, 4'd1, 4'd3, 4'd3, 4'd0, 4'd0, 4'd3, 4'd2, 4'd3,
        4'd1, 4'd3, 4'd2, 4'd4, 4'd4, 4'd1, 4'd3, 4'd5, 4'd0, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd3, 4'd3, 4'd0, 4'd4, 4'd1, 4'd9, 4'd3,
        4'd1, 4'd1, 4'd1, 4'd3, 4'd5, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1, 4'd3,
        4'd4, 4'd4, 4'd0, 4'd5, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd2, 4'd1, 4'd1, 4'd4, 4'd4, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd1, 4'd0,
        4'd1
    };

    function automatic logic [3:0] len_of(input logic [7:0] op);
        logic [3:0] len;
        if (op >= 8'(OPCODE_COUNT)) begin
            len = 4'd0;
        end
        else begin
            len = LEN_TAB[op];
        end
        return len;
    endfunction

    function automatic var_rule_t rule_of(input logic [7:0] op);
        var_rule_t r;
        r = '{kind: KIND_NONE, hdr: 3'd1, fpos: 2'd0, fnum: 2'd0, add: 3'd0, dbl: 1'b0};
        unique case (op)
            OP_FIELD16:
            begin
                r = '{kind: KIND_LEN, hdr: 3'd3, fpos: 2'd1, fnum: 2'd2, add: 3'd0, dbl: 1'b0};
            end
            OP_FIELD8:
            begin
                r = '{kind: KIND_LEN, hdr: 3'd2, fpos: 2'd1, fnum: 2'd1, add: 3'd0, dbl: 1'b0};
            end
            OP_FIELD24:
            begin
                r = '{kind: KIND_LEN, hdr: 3'd4, fpos: 2'd1, fnum: 2'd3, add: 3'd0, dbl: 1'b0};
            end
            OP_FIELD16_HDR:
            begin
                r = '{kind: KIND_LEN, hdr: 3'd3, fpos: 2'd1, fnum: 2'd2, add: 3'd3, dbl: 1'b0};
            end
            OP_FIELD8_HDR:
            begin
                r = '{kind: KIND_LEN, hdr: 3'd2, fpos: 2'd1, fnum: 2'd1, add: 3'd2, dbl: 1'b0};
            end
            OP_FIELD24_HDR:
            begin
                r = '{kind: KIND_LEN, hdr: 3'd4, fpos: 2'd1, fnum: 2'd3, add: 3'd4, dbl: 1'b0};
            end
            OP_HIDDEN_STR:
            begin
                r = '{kind: KIND_LEN, hdr: 3'd4, fpos: 2'd2, fnum: 2'd2, add: 3'd4, dbl: 1'b0};
            end
            OP_THREAD_STATICS:
            begin
                r = '{kind: KIND_LEN, hdr: 3'd3, fpos: 2'd1, fnum: 2'd2, add: 3'd3, dbl: 1'b1};
            end
            OP_SCAN_HDR3:
            begin
                r = '{kind: KIND_SCAN, hdr: 3'd3, fpos: 2'd0, fnum: 2'd0, add: 3'd0, dbl: 1'b0};
            end
            OP_SCAN:
            begin
                r = '{kind: KIND_SCAN, hdr: 3'd1, fpos: 2'd0, fnum: 2'd0, add: 3'd0, dbl: 1'b0};
            end
            OP_SCAN_HDR4:
            begin
                r = '{kind: KIND_SCAN, hdr: 3'd4, fpos: 2'd0, fnum: 2'd0, add: 3'd0, dbl: 1'b0};
            end
            default:
            begin
                r.kind = KIND_NONE;
            end
        endcase
        return r;
    endfunction

    // low 32 bits of an offset, zero extended when the counter is narrower
    function automatic logic [31:0] offset_to_out(input logic [OFFSET_BITS-1:0] off);
        logic [63:0] wide;
        wide = 64'(off);
        return wide[31:0];
    endfunction

endpackage

/* rtl/core/bilw_in_stage.sv */
// input register for the code byte stream
module bilw_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            code_valid,
    output logic            code_stall,
    input  logic [7:0]      code_byte,
    input  logic            last_byte,
    input  logic            take,
    output bilw_pkg::item_t item
);

    logic       full_reg;
    logic       full_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       last_reg;
    logic       last_next;
    logic       accept;

    // blocked only while the held byte cannot move on
    assign code_stall = full_reg && !take;
    assign accept     = code_valid && !code_stall;

    always_comb
    begin
        full_next = full_reg;
        byte_next = byte_reg;
        last_next = last_reg;
        if (accept)
        begin
            full_next = 1'b1;
            byte_next = code_byte;
            last_next = last_byte;
        end
        else if (take)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign item = '{valid: full_reg, code_byte: byte_reg, last_byte: last_reg};

endmodule

/* rtl/core/bilw_walker.sv */
// per-byte walk state and instruction boundary logic
module bilw_walker (
    input  logic              clk,
    input  logic              rst_n,
    input  bilw_pkg::item_t   item,
    input  logic              space,
    output logic              take,
    output logic              res_load,
    output bilw_pkg::result_t res_data
);

    typedef enum logic [1:0] {
        MODE_OPCODE,
        MODE_HEADER,
        MODE_BODY,
        MODE_SCAN
    } walk_mode_t;

    walk_mode_t                         mode_reg;
    walk_mode_t                         mode_next;
    logic [bilw_pkg::OFFSET_BITS-1:0]   pos_reg;
    logic [bilw_pkg::OFFSET_BITS-1:0]   pos_next;
    logic [bilw_pkg::OFFSET_BITS-1:0]   start_reg;
    logic [bilw_pkg::OFFSET_BITS-1:0]   start_next;
    logic [7:0]                         op_reg;
    logic [7:0]                         op_next;
    logic [2:0]                         hidx_reg;
    logic [2:0]                         hidx_next;
    logic [bilw_pkg::ACC_BITS-1:0]      acc_reg;
    logic [bilw_pkg::ACC_BITS-1:0]      acc_next;
    logic [bilw_pkg::LEN_BITS-1:0]      rem_reg;
    logic [bilw_pkg::LEN_BITS-1:0]      rem_next;
    logic [bilw_pkg::LEN_BITS-1:0]      total_reg;
    logic [bilw_pkg::LEN_BITS-1:0]      total_next;

    bilw_pkg::var_rule_t                hdr_rule;
    bilw_pkg::var_rule_t                byte_rule;
    logic [3:0]                         byte_len;
    logic                               byte_bad;
    logic [2:0]                         rel;
    logic                               in_field;
    logic [bilw_pkg::ACC_BITS-1:0]      acc_merged;
    logic [bilw_pkg::LEN_BITS-1:0]      tot;
    logic [bilw_pkg::LEN_BITS-1:0]      hdr_len;
    logic [bilw_pkg::LEN_BITS-1:0]      cnt;
    logic                               fire;
    logic [bilw_pkg::LEN_BITS-1:0]      res_len;
    bilw_pkg::status_t                  res_status;

    assign take = item.valid && space;

    assign hdr_rule  = bilw_pkg::rule_of(op_reg);
    assign byte_rule = bilw_pkg::rule_of(item.code_byte);
    assign byte_len  = bilw_pkg::len_of(item.code_byte);
    assign byte_bad  = item.code_byte >= 8'(bilw_pkg::OPCODE_COUNT);

    // little-endian length field lane
    assign rel      = hidx_reg - 3'(hdr_rule.fpos);
    assign in_field = (hidx_reg >= 3'(hdr_rule.fpos)) && (rel < 3'(hdr_rule.fnum));

    always_comb
    begin
        acc_merged = acc_reg;
        if (in_field)
        begin
            unique case (rel[1:0])
                2'd0:    acc_merged[7:0]   = acc_reg[7:0]   | item.code_byte;
                2'd1:    acc_merged[15:8]  = acc_reg[15:8]  | item.code_byte;
                2'd2:    acc_merged[23:16] = acc_reg[23:16] | item.code_byte;
                default: acc_merged = acc_reg;
            endcase
        end
    end

    assign tot = bilw_pkg::LEN_BITS'(hdr_rule.add)
               + (hdr_rule.dbl ? {acc_merged, 1'b0} : {1'b0, acc_merged});
    assign hdr_len = bilw_pkg::LEN_BITS'(hdr_rule.hdr);

    // scan count saturates at the top of the length range
    assign cnt = (rem_reg == bilw_pkg::LEN_MAX) ? bilw_pkg::LEN_MAX
                                                : rem_reg + bilw_pkg::LEN_BITS'(1);

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        op_next    = op_reg;
        hidx_next  = hidx_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        total_next = total_reg;
        fire       = 1'b0;
        res_len    = '0;
        res_status = bilw_pkg::ST_OK;
        if (take)
        begin
            unique case (mode_reg)
                MODE_HEADER:
                begin
                    acc_next  = acc_merged;
                    hidx_next = hidx_reg + 3'd1;
                    if (hidx_next >= hdr_rule.hdr)
                    begin
                        if (hdr_rule.kind == bilw_pkg::KIND_SCAN)
                        begin
                            mode_next = MODE_SCAN;
                            rem_next  = hdr_len;
                        end
                        else
                        begin
                            total_next = tot;
                            if (tot < hdr_len)
                            begin
                                fire       = 1'b1;
                                res_len    = tot;
                                res_status = bilw_pkg::ST_SHORT_LEN;
                            end
                            else if (tot == hdr_len)
                            begin
                                fire    = 1'b1;
                                res_len = tot;
                            end
                            else
                            begin
                                mode_next = MODE_BODY;
                                rem_next  = tot - hdr_len;
                            end
                        end
                    end
                end
                MODE_BODY:
                begin
                    if (rem_reg != '0)
                    begin
                        rem_next = rem_reg - bilw_pkg::LEN_BITS'(1);
                    end
                    if (rem_next == '0)
                    begin
                        fire    = 1'b1;
                        res_len = total_reg;
                    end
                end
                MODE_SCAN:
                begin
                    if (item.code_byte == 8'd0)
                    begin
                        fire    = 1'b1;
                        res_len = cnt;
                    end
                    else
                    begin
                        rem_next = cnt;
                    end
                end
                MODE_OPCODE:
                begin
                    start_next = pos_reg;
                    op_next    = item.code_byte;
                    hidx_next  = 3'd1;
                    acc_next   = '0;
                    rem_next   = '0;
                    if (byte_bad)
                    begin
                        fire       = 1'b1;
                        res_len    = bilw_pkg::LEN_BITS'(1);
                        res_status = bilw_pkg::ST_BAD_OPCODE;
                    end
                    else if (byte_len == 4'd1)
                    begin
                        fire    = 1'b1;
                        res_len = bilw_pkg::LEN_BITS'(1);
                    end
                    else if (byte_len > 4'd1)
                    begin
                        mode_next  = MODE_BODY;
                        total_next = bilw_pkg::LEN_BITS'(byte_len);
                        rem_next   = bilw_pkg::LEN_BITS'(byte_len - 4'd1);
                    end
                    else if (byte_rule.kind == bilw_pkg::KIND_NONE)
                    begin
                        fire       = 1'b1;
                        res_len    = bilw_pkg::LEN_BITS'(1);
                        res_status = bilw_pkg::ST_ZERO_SIZE;
                    end
                    else if (byte_rule.kind == bilw_pkg::KIND_SCAN && byte_rule.hdr == 3'd1)
                    begin
                        mode_next = MODE_SCAN;
                        rem_next  = bilw_pkg::LEN_BITS'(1);
                    end
                    else
                    begin
                        mode_next = MODE_HEADER;
                    end
                end
                default:
                begin
                    mode_next = MODE_OPCODE;
                end
            endcase

            // stream ended before the instruction did: report the bytes seen
            if (!fire && item.last_byte)
            begin
                fire       = 1'b1;
                res_status = bilw_pkg::ST_TRUNCATED;
                unique case (mode_next)
                    MODE_HEADER: res_len = bilw_pkg::LEN_BITS'(hidx_next);
                    MODE_BODY:   res_len = total_next - rem_next;
                    default:     res_len = rem_next;
                endcase
            end

            if (fire || item.last_byte)
            begin
                mode_next = MODE_OPCODE;
            end
            if (item.last_byte)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + bilw_pkg::OFFSET_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_OPCODE;
            pos_reg   <= '0;
            start_reg <= '0;
            op_reg    <= '0;
            hidx_reg  <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            op_reg    <= op_next;
            hidx_reg  <= hidx_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            total_reg <= total_next;
        end
    end

    assign res_load = take && fire;
    assign res_data = '{start_offset: bilw_pkg::offset_to_out(start_next),
                        instr_length: res_len,
                        opcode_value: op_next,
                        status:       res_status};

endmodule

/* rtl/core/bilw_out_stage.sv */
// result register for finished instructions
module bilw_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  bilw_pkg::result_t             res_in,
    output logic                          space,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [31:0]                   start_offset,
    output logic [bilw_pkg::LEN_BITS-1:0] instr_length,
    output logic [7:0]                    opcode_value,
    output logic [2:0]                    status
);

    logic              valid_reg;
    logic              valid_next;
    bilw_pkg::result_t data_reg;
    bilw_pkg::result_t data_next;

    // room when empty or when the held transaction leaves this cycle
    assign space = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = res_in;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result_valid = valid_reg;
    assign start_offset = data_reg.start_offset;
    assign instr_length = data_reg.instr_length;
    assign opcode_value = data_reg.opcode_value;
    assign status       = data_reg.status;

endmodule

/* rtl/core/bytecode_instruction_length_walker_core.sv */
// top level of the bytecode instruction length walker
//
// Walks a function's bytecode one byte per transaction and reports each
// instruction boundary as one result transaction: the offset where the
// instruction starts, its length in bytes, its opcode byte and a status
// (ok, bad opcode, zero-size opcode, declared length shorter than the header,
// or stream ended mid-instruction). Bytes that fall inside an instruction give
// no result. Opcodes 0..180 take their length from a fixed table; a handful of
// opcodes read a little-endian length field from the header, double a 16-bit
// count, or skip a header and scan through a zero terminator (scan lengths
// saturate at 2^25-1). A byte flagged with last_byte ends the function: an
// unfinished instruction is reported as truncated and the offset restarts at
// zero. Throughput is one byte per clock, sustained while result_stall is low;
// the walk state updates on each byte, between the input register and the
// result register. A result enters the result register when the walker steps
// on the byte that finishes its instruction. While a finished result waits
// under result_stall the walker steps on no further byte, whether or not that
// byte would end an instruction; the input register then fills and code_stall
// stays high until the result leaves.
module bytecode_instruction_length_walker_core (
    input  logic        clk,
    input  logic        rst_n,

    // code byte transactions
    input  logic        code_valid,
    output logic        code_stall,
    input  logic [7:0]  code_byte,
    input  logic        last_byte,

    // instruction result transactions
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] start_offset,
    output logic [24:0] instr_length,
    output logic [7:0]  opcode_value,
    output logic [2:0]  status
);

    bilw_pkg::item_t   item;
    bilw_pkg::result_t res_data;
    logic              take;
    logic              space;
    logic              res_load;

    // byte held here until the walker can step on it
    bilw_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_byte  (code_byte),
        .last_byte  (last_byte),
        .take       (take),
        .item       (item)
    );

    // walk state: opcode, header, body or terminator scan
    bilw_walker u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .space    (space),
        .take     (take),
        .res_load (res_load),
        .res_data (res_data)
    );

    // finished instructions wait here for the consumer
    bilw_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (res_load),
        .res_in       (res_data),
        .space        (space),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .start_offset (start_offset),
        .instr_length (instr_length),
        .opcode_value (opcode_value),
        .status       (status)
    );

`ifndef SYNTHESIS
    // input only backs up when a byte is held and the result register is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        code_stall |-> (item.valid && result_valid && result_stall))
        else $error("code_stall without a blocked result");

    // a bad opcode is always a one-byte instruction above the table
    a_bad_opcode: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == bilw_pkg::ST_BAD_OPCODE)
        |-> (instr_length == 25'd1 && opcode_value >= 8'(bilw_pkg::OPCODE_COUNT)))
        else $error("bad opcode result with wrong length or opcode");

    // a good instruction always covers at least its opcode byte
    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == bilw_pkg::ST_OK) |-> (instr_length != 25'd0))
        else $error("ok result with zero length");

    // a new result only follows a byte that was held in the input register
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item.valid))
        else $error("result appeared without a code byte");
`endif

endmodule

/* bench/tb_bytecode_instruction_length_walker_core.sv */
// self-checking testbench for the bytecode instruction length walker core
module tb_bytecode_instruction_length_walker_core;

    import bilw_pkg::*;

    // cycles without any transaction on either side before the run is called dead
    localparam int unsigned QUIET_LIMIT = 3000;
    // random part sizes, in code bytes
    localparam int unsigned FIRST_HALF  = 900;
    localparam int unsigned SECOND_HALF = 330;
    // receiver hold-off: starts after this many results, lasts this many cycles
    localparam int unsigned HOLD_AFTER  = 250;
    localparam int unsigned HOLD_CYCLES = 400;
    // window of cycles with no idling on either side
    localparam int unsigned CALM_FROM   = 1500;
    localparam int unsigned CALM_TO     = 3500;

    // opcodes used by name in the directed part
    localparam logic [7:0] OP_ONE_BYTE   = 8'd0;
    localparam logic [7:0] OP_THREE_BYTE = 8'd3;
    localparam logic [7:0] OP_ZERO_SIZE  = 8'd59;
    localparam logic [7:0] OP_BAD_LOW    = 8'd181;
    localparam logic [7:0] OP_BAD_TOP    = 8'd255;

    localparam logic [7:0] VAR_OPS [11] = '{
        OP_SCAN_HDR3, OP_SCAN, OP_FIELD16, OP_FIELD8, OP_FIELD16_HDR, OP_FIELD8_HDR,
        OP_SCAN_HDR4, OP_HIDDEN_STR, OP_FIELD24, OP_FIELD24_HDR, OP_THREAD_STATICS
    };

    // fixed instruction length per opcode, zero for variable or invalid
    localparam int unsigned INSTR_LEN [OPCODE_COUNT] = '{
        1, 1, 1, 3, 3, 1, 1, 1, 1, 1,
        1, 3, 2, 3, 1, 1, 1, 1, 1, 3,
        2, 1, 9, 1, 1, 2, 3, 4, 2, 3,
        4, 2, 3, 4, 1, 1, 3, 0, 2, 2,
        2, 3, 2, 1, 2, 2, 1, 1, 3, 1,
        1, 0, 3, 3, 3, 3, 3, 3, 3, 0,
        3, 3, 3, 3, 3, 1, 1, 1, 1, 1,
        1, 4, 1, 1, 1, 3, 2, 3, 3, 3,
        2, 3, 3, 3, 1, 1, 3, 2, 3, 0,
        0, 3, 2, 3, 3, 2, 3, 5, 3, 3,
        1, 11, 1, 3, 3, 0, 0, 3, 2, 3,
        1, 3, 2, 4, 4, 1, 3, 5, 0, 1,
        1, 1, 1, 3, 3, 0, 4, 1, 9, 3,
        1, 1, 1, 3, 5, 1, 1, 1, 1, 1,
        1, 1, 1, 1, 3, 1, 3, 1, 1, 3,
        4, 4, 0, 5, 1, 1, 1, 1, 1, 0,
        0, 0, 0, 2, 1, 1, 4, 4, 1, 1,
        1, 1, 1, 3, 3, 3, 3, 3, 1, 0,
        1
    };

    typedef enum logic [1:0] {
        WALK_OPCODE,
        WALK_HEADER,
        WALK_BODY,
        WALK_SCAN
    } walk_t;

    // how a generated instruction ends the function
    typedef enum {
        END_OPEN,   // no last_byte
        END_LAST,   // last_byte on its final byte
        END_CUT     // last_byte somewhere before its end
    } tail_t;

    typedef struct packed {
        logic [7:0] value;
        logic       ends_fn;
    } code_item_t;

    typedef struct {
        logic [31:0] start;
        logic [24:0] len;
        logic [7:0]  op;
        status_t     st;
    } boundary_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        code_valid = 1'b0;
    logic        code_stall;
    logic [7:0]  code_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] start_offset;
    logic [24:0] instr_length;
    logic [7:0]  opcode_value;
    logic [2:0]  status;

    code_item_t  code_q[$];       // code bytes waiting to be offered
    boundary_t   boundary_q[$];   // instruction boundaries still to be reported

    int unsigned fed = 0;
    int unsigned fail_count = 0;
    int unsigned cyc = 0;
    int unsigned quiet = 0;
    int unsigned results_seen = 0;
    int unsigned hold_left = 0;
    bit          held_once = 1'b0;

    // walk state of the prediction, at its reset values
    walk_t       w_mode = WALK_OPCODE;
    logic [31:0] w_pos = '0;
    logic [31:0] w_start = '0;
    logic [7:0]  w_op = '0;
    int unsigned w_hidx = 0;
    logic [23:0] w_acc = '0;
    int unsigned w_rem = 0;

    bytecode_instruction_length_walker_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .code_valid   (code_valid),
        .code_stall   (code_stall),
        .code_byte    (code_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .start_offset (start_offset),
        .instr_length (instr_length),
        .opcode_value (opcode_value),
        .status       (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // variable length rule of an opcode, kind none for everything else
    function automatic var_rule_t length_rule(input logic [7:0] op);
        var_rule_t r;
        r = '{KIND_NONE, 3'd1, 2'd0, 2'd0, 3'd0, 1'b0};
        case (op)
            OP_FIELD16:        r = '{KIND_LEN, 3'd3, 2'd1, 2'd2, 3'd0, 1'b0};
            OP_FIELD8:         r = '{KIND_LEN, 3'd2, 2'd1, 2'd1, 3'd0, 1'b0};
            OP_FIELD24:        r = '{KIND_LEN, 3'd4, 2'd1, 2'd3, 3'd0, 1'b0};
            OP_FIELD16_HDR:    r = '{KIND_LEN, 3'd3, 2'd1, 2'd2, 3'd3, 1'b0};
            OP_FIELD8_HDR:     r = '{KIND_LEN, 3'd2, 2'd1, 2'd1, 3'd2, 1'b0};
            OP_FIELD24_HDR:    r = '{KIND_LEN, 3'd4, 2'd1, 2'd3, 3'd4, 1'b0};
            OP_HIDDEN_STR:     r = '{KIND_LEN, 3'd4, 2'd2, 2'd2, 3'd4, 1'b0};
            OP_THREAD_STATICS: r = '{KIND_LEN, 3'd3, 2'd1, 2'd2, 3'd3, 1'b1};
            OP_SCAN_HDR3:      r = '{KIND_SCAN, 3'd3, 2'd0, 2'd0, 3'd0, 1'b0};
            OP_SCAN:           r = '{KIND_SCAN, 3'd1, 2'd0, 2'd0, 3'd0, 1'b0};
            OP_SCAN_HDR4:      r = '{KIND_SCAN, 3'd4, 2'd0, 2'd0, 3'd0, 1'b0};
            default:           r.kind = KIND_NONE;
        endcase
        return r;
    endfunction

    // declared total of an instruction: table length, or field (doubled by rule) plus offset
    function automatic int unsigned full_length(input logic [7:0] op, input logic [23:0] acc);
        var_rule_t r;
        if (op < OPCODE_COUNT)
        begin
            if (INSTR_LEN[op] != 0)
                return INSTR_LEN[op];
        end
        r = length_rule(op);
        return 32'(r.add) + (32'(acc) << r.dbl);
    endfunction

    function automatic void note_boundary(input int unsigned len, input status_t st);
        boundary_t b;
        b.start = w_start;
        b.len   = 25'(len);
        b.op    = w_op;
        b.st    = st;
        boundary_q.push_back(b);
    endfunction

    // one accepted code byte through the predicted walk
    function automatic void advance_walk(input logic [7:0] b, input logic fin);
        var_rule_t   r;
        int unsigned fp, fn, hd, tot, cnt, got;
        bit          fired;
        fired = 1'b0;
        case (w_mode)
            WALK_HEADER:
            begin
                r  = length_rule(w_op);
                fp = r.fpos;
                fn = r.fnum;
                hd = r.hdr;
                // little-endian length field inside the header
                if (w_hidx >= fp && w_hidx < fp + fn)
                    w_acc = w_acc | 24'(32'(b) << (8 * ((w_hidx - fp) & 3)));
                w_hidx = w_hidx + 1;
                if (w_hidx >= hd)
                begin
                    if (r.kind == KIND_SCAN)
                    begin
                        w_mode = WALK_SCAN;
                        w_rem  = hd;
                    end
                    else
                    begin
                        tot = full_length(w_op, w_acc);
                        if (tot < hd)
                        begin
                            note_boundary(tot, ST_SHORT_LEN);
                            fired = 1'b1;
                        end
                        else if (tot == hd)
                        begin
                            note_boundary(tot, ST_OK);
                            fired = 1'b1;
                        end
                        else
                        begin
                            w_mode = WALK_BODY;
                            w_rem  = tot - hd;
                        end
                    end
                end
            end
            WALK_BODY:
            begin
                if (w_rem > 0)
                    w_rem = w_rem - 1;
                if (w_rem == 0)
                begin
                    note_boundary(full_length(w_op, w_acc), ST_OK);
                    fired = 1'b1;
                end
            end
            WALK_SCAN:
            begin
                // scan count saturates
                cnt = (w_rem >= 32'(LEN_MAX)) ? 32'(LEN_MAX) : w_rem + 1;
                if (b == 8'd0)
                begin
                    note_boundary(cnt, ST_OK);
                    fired = 1'b1;
                end
                else
                    w_rem = cnt;
            end
            default:
            begin
                w_start = w_pos;
                w_op    = b;
                w_hidx  = 1;
                w_acc   = '0;
                w_rem   = 0;
                r       = length_rule(b);
                if (b >= OPCODE_COUNT)
                begin
                    note_boundary(1, ST_BAD_OPCODE);
                    fired = 1'b1;
                end
                else if (INSTR_LEN[b] == 1)
                begin
                    note_boundary(1, ST_OK);
                    fired = 1'b1;
                end
                else if (INSTR_LEN[b] > 1)
                begin
                    w_mode = WALK_BODY;
                    w_rem  = INSTR_LEN[b] - 1;
                end
                else if (r.kind == KIND_NONE)
                begin
                    note_boundary(1, ST_ZERO_SIZE);
                    fired = 1'b1;
                end
                else if (r.kind == KIND_SCAN && r.hdr == 3'd1)
                begin
                    w_mode = WALK_SCAN;
                    w_rem  = 1;
                end
                else
                    w_mode = WALK_HEADER;
            end
        endcase

        // function ends inside an instruction
        if (!fired && fin)
        begin
            if (w_mode == WALK_HEADER)
                got = w_hidx;
            else if (w_mode == WALK_BODY)
                got = full_length(w_op, w_acc) - w_rem;
            else
                got = w_rem;
            note_boundary(got, ST_TRUNCATED);
            fired = 1'b1;
        end

        if (fired)
            w_mode = WALK_OPCODE;
        if (fin)
        begin
            w_mode = WALK_OPCODE;
            w_pos  = '0;
        end
        else
            w_pos = w_pos + 1;
    endfunction

    function automatic bit coin_idle();
        if (cyc >= CALM_FROM && cyc < CALM_TO)
            return 1'b0;
        return $urandom_range(99) < 31;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    function automatic void push_code(input logic [7:0] value, input logic ends_fn);
        code_q.push_back('{value, ends_fn});
        fed++;
    endfunction

    // one instruction of opcode op; field is the length field, or for scan
    // opcodes the number of non-zero bytes before the terminator
    function automatic void queue_instr(input logic [7:0] op, input int unsigned field,
                                        input tail_t tail);
        logic [7:0]  seq[$];
        var_rule_t   r;
        int unsigned total, cap, n, fp, fn, cut;
        r   = length_rule(op);
        fp  = r.fpos;
        fn  = r.fnum;
        // a cut instruction never needs more than its first 80 bytes
        cap = (tail == END_CUT) ? 80 : 32'hFFFF_FFFF;
        if (op >= OPCODE_COUNT)
            total = 1;
        else if (INSTR_LEN[op] != 0)
            total = INSTR_LEN[op];
        else if (r.kind == KIND_LEN)
            total = 32'(r.add) + (field << r.dbl);
        else
            total = r.hdr;
        if (total < r.hdr)
            total = r.hdr;
        seq.push_back(op);
        while (seq.size() < total && seq.size() < cap)
        begin
            n = seq.size();
            if (r.kind == KIND_LEN && n >= fp && n < fp + fn)
                seq.push_back(8'(field >> (8 * (n - fp))));
            else
                seq.push_back(8'($urandom));
        end
        if (r.kind == KIND_SCAN)
        begin
            repeat (field) seq.push_back(8'($urandom_range(255, 1)));
            seq.push_back(8'h00);
        end
        if (tail == END_CUT && seq.size() > 1)
        begin
            cut = $urandom_range(seq.size() - 2);
            while (seq.size() > cut + 1)
                void'(seq.pop_back());
        end
        foreach (seq[i])
            push_code(seq[i], tail != END_OPEN && i == seq.size() - 1);
    endfunction

    // mostly well-formed instructions with random content, some noise
    function automatic void queue_random_instr();
        int unsigned pick, field;
        logic [7:0]  op;
        var_rule_t   r;
        tail_t       tail;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            push_code(8'($urandom), $urandom_range(99) < 20);
            return;
        end
        if (pick < 38)
            op = VAR_OPS[$urandom_range(10)];
        else if (pick < 46)
            op = 8'($urandom_range(255, OPCODE_COUNT));
        else
            op = 8'($urandom_range(OPCODE_COUNT - 1));
        pick = $urandom_range(99);
        tail = (pick < 9) ? END_CUT : (pick < 13) ? END_LAST : END_OPEN;
        r    = length_rule(op);
        pick = $urandom_range(99);
        if (r.kind == KIND_SCAN)
            field = $urandom_range(12);
        else if (pick < 30)
            field = $urandom_range(r.hdr + 2);   // around the header size
        else if (pick < 85)
            field = $urandom_range(40);
        else
        begin
            // huge declared lengths, only ever cut short
            field = $urandom;
            tail  = END_CUT;
        end
        // scan opcodes keep their terminator distance
        if (r.kind != KIND_SCAN)
            field = field & ((32'd1 << (8 * r.fnum)) - 1);
        queue_instr(op, field, tail);
    endfunction

    task automatic drain_all();
        while (code_q.size() != 0 || code_valid || boundary_q.size() != 0)
            @(posedge clk);
    endtask

    // driver: offers queued code bytes, predicts on each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin : code_driver
        code_item_t next;
        if (!rst_n)
        begin
            code_valid <= 1'b0;
            code_byte  <= 8'd0;
            last_byte  <= 1'b0;
        end
        else
        begin
            if (code_valid && !code_stall)
                advance_walk(code_byte, last_byte);
            // payload only moves once the current transaction is taken
            if (!code_valid || !code_stall)
            begin
                if (code_q.size() != 0 && !coin_idle())
                begin
                    next = code_q.pop_front();
                    code_valid <= 1'b1;
                    code_byte  <= next.value;
                    last_byte  <= next.ends_fn;
                end
                else
                    code_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transaction against the oldest boundary
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        boundary_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (boundary_q.size() == 0)
                begin
                    fail_count++;
                    $error("result with nothing pending: start_offset %0d, opcode_value %0d",
                           start_offset, opcode_value);
                end
                else
                begin
                    want = boundary_q.pop_front();
                    check_field("start_offset", want.start, start_offset);
                    check_field("instr_length", 32'(want.len), 32'(instr_length));
                    check_field("opcode_value", 32'(want.op), 32'(opcode_value));
                    check_field("status", 32'(want.st), 32'(status));
                end
                // long hold-off once, so the block backs up into its input
                if (results_seen == HOLD_AFTER && !held_once)
                begin
                    hold_left = HOLD_CYCLES;
                    held_once = 1'b1;
                end
            end
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= coin_idle();
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (!rst_n || (code_valid && !code_stall) || (result_valid && !result_stall))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin : stimulus
        int unsigned goal;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, bad and zero-size opcodes, short and exact
        // declared lengths, scan, truncation
        queue_instr(OP_ONE_BYTE, 0, END_OPEN);
        queue_instr(OP_BAD_TOP, 0, END_OPEN);
        queue_instr(OP_ZERO_SIZE, 0, END_OPEN);
        queue_instr(OP_BAD_LOW, 0, END_LAST);     // bad opcode on last byte stays bad
        queue_instr(OP_FIELD16, 0, END_OPEN);     // declared total zero, below header
        queue_instr(OP_FIELD8, 2, END_OPEN);      // declared total equals header
        queue_instr(OP_FIELD8_HDR, 1, END_OPEN);  // one body byte
        queue_instr(OP_SCAN, 1, END_LAST);        // terminator on the last byte
        push_code(OP_THREE_BYTE, 1'b0);           // fixed length cut after two bytes
        push_code(8'h00, 1'b1);
        push_code(OP_FIELD24, 1'b0);              // largest field, cut in the body
        push_code(8'hFF, 1'b0);
        push_code(8'hFF, 1'b0);
        push_code(8'hFF, 1'b0);
        push_code(8'hFF, 1'b1);

        // sender pause: let every expected result come out
        drain_all();

        goal = fed + FIRST_HALF;
        while (fed < goal)
            queue_random_instr();

        // one full instruction with a doubled count that uses both field bytes
        queue_instr(OP_THREAD_STATICS, 32'h0101, END_OPEN);

        goal = fed + SECOND_HALF;
        while (fed < goal)
            queue_random_instr();

        drain_all();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
